/* design/gdnc_pkg.sv */
// Shared constants and types for the Gaussian divergence nearest-class search.
package gdnc_pkg;

  localparam int unsigned SCORE_W = 40;
  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;
  localparam logic [SCORE_W-1:0] SCORE_BOUND = 40'd65536000000;

  localparam logic CMD_REF   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLASS = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

/* design/gdnc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gdnc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/gdnc_div.sv */
// Restoring divider, one quotient bit per cycle: sat40((num << 16) / den).
module gdnc_div #(
  parameter int unsigned NW = 37
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [NW-1:0]                   num,
  input  logic [NW-1:0]                   den,
  output logic                            done,
  output logic [gdnc_pkg::SCORE_W-1:0]    quo
);

  localparam int unsigned DW = NW + 16;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dq_r, dq_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   trial;
  logic [NW:0]   diff;

  always_comb begin
    trial    = {rem_r, dq_r[DW-1]};
    diff     = trial - {1'b0, den_r};
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = {num, 16'd0};
      rem_nxt  = '0;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[NW]) begin
        rem_nxt = diff[NW-1:0];
        dq_nxt  = {dq_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[NW-1:0];
        dq_nxt  = {dq_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = (|dq_r[DW-1:gdnc_pkg::SCORE_W]) ? gdnc_pkg::SCORE_SAT
                                                 : dq_r[gdnc_pkg::SCORE_W-1:0];

endmodule

/* design/gaussian_divergence_nearest_class.sv */
// Top level: reference frame store and nearest-class divergence search.
// Reference pairs and query pairs are taken one per cycle while no search
// is running. A query pair flagged last starts a search that holds off new
// items until the result is registered. The search walks every stored frame
// of every class in use through the single reference RAM read port: per
// frame, one read per coefficient, a drain of the RAM read register, product
// registers and accumulators, then two parallel bit-serial dividers whose
// dividend width depends on COEFFS (53 bits at 16 coefficients), then a
// compare against the best score. Empty classes are skipped without reads.
// The result waits in an output register.
module gaussian_divergence_nearest_class #(
  parameter int unsigned COEFFS      = 16,
  parameter int unsigned MAX_CLASSES = 16,
  parameter int unsigned MAX_FRAMES  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [3:0]  in_class_sel,
  input  logic [9:0]  in_frame_sel,
  input  logic [3:0]  in_coeff_sel,
  input  logic signed [15:0] in_mean_value,
  input  logic signed [15:0] in_var_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_winner_class,
  output logic        out_found,
  output logic [39:0] out_min_distance
);

  localparam int unsigned DEPTH = MAX_CLASSES * MAX_FRAMES * COEFFS;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned KW    = COEFFS > 1 ? $clog2(COEFFS) : 1;
  localparam int unsigned CIW   = MAX_CLASSES > 1 ? $clog2(MAX_CLASSES) : 1;
  localparam int unsigned CNW   = $clog2(MAX_CLASSES + 1);
  localparam int unsigned FCW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SQW   = 32 + (COEFFS > 1 ? $clog2(COEFFS) : 0);
  localparam int unsigned NW    = SQW + 1;
  localparam int unsigned CSTEP = MAX_FRAMES * COEFFS;
  localparam int unsigned SW    = gdnc_pkg::SCORE_W;

  gdnc_pkg::state_t state_r, state_nxt;

  logic [4:0]        num_classes_r;
  logic [FCW-1:0]    frame_cnt_r [MAX_CLASSES];
  logic [15:0]       qm_r [COEFFS];
  logic [15:0]       qv_r [COEFFS];

  logic [CNW-1:0]    cls_r;
  logic [FCW-1:0]    frm_r, cnt_r;
  logic [KW-1:0]     k_r;
  logic [AW-1:0]     addr_r, base_r;
  logic              rd_vld_r, p_vld_r;
  logic [KW-1:0]     rd_k_r;
  logic [31:0]       pa_r, pb_r, pc_r;
  logic [SQW-1:0]    acc_a_r, acc_b_r, acc_c_r;
  logic [SW-1:0]     best_r;
  logic [CNW-1:0]    win_r;
  logic              found_r;

  logic              out_valid_r;
  logic [3:0]        out_win_r;
  logic              out_found_r;
  logic [SW-1:0]     out_dist_r;

  logic              in_acc, ref_ok, q_ok;
  logic [AW-1:0]     waddr;
  logic [FCW-1:0]    new_cnt;
  logic [CIW-1:0]    wcls;
  logic [CNW-1:0]    used;
  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic signed [15:0] qm_s, qv_s, rm_s, rv_s;
  logic signed [16:0] dm;
  logic signed [33:0] dsq;
  logic signed [31:0] asq, bsq;
  logic              div_start, d0_done, d1_done;
  logic [SW-1:0]     q0, q1;
  logic [SW:0]       dsum;
  logic [SW-1:0]     dsat;

  assign in_stall = (state_r != gdnc_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ref_ok   = (32'(in_class_sel) < MAX_CLASSES) && (32'(in_frame_sel) < MAX_FRAMES)
                    && (32'(in_coeff_sel) < COEFFS);
  assign q_ok     = 32'(in_coeff_sel) < COEFFS;
  assign ram_we   = in_acc && (in_cmd == gdnc_pkg::CMD_REF) && ref_ok;
  assign waddr    = AW'((32'(in_class_sel) * MAX_FRAMES + 32'(in_frame_sel)) * COEFFS
                        + 32'(in_coeff_sel));
  assign new_cnt  = FCW'(32'(in_frame_sel) + 1);
  assign wcls     = CIW'(in_class_sel);
  assign used     = (32'(num_classes_r) > MAX_CLASSES) ? CNW'(MAX_CLASSES)
                                                       : CNW'(num_classes_r);

  gdnc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({in_mean_value, in_var_value}),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // product stage operands
  assign qm_s = qm_r[rd_k_r];
  assign qv_s = qv_r[rd_k_r];
  assign rm_s = ram_rdata[31:16];
  assign rv_s = ram_rdata[15:0];
  assign dm   = {qm_s[15], qm_s} - {rm_s[15], rm_s};
  assign dsq  = dm * dm;
  assign asq  = qv_s * qv_s;
  assign bsq  = rv_s * rv_s;

  assign div_start = (state_r == gdnc_pkg::S_DRAIN) && !rd_vld_r && !p_vld_r;

  gdnc_div #(.NW(NW)) u_div_ref (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NW'(acc_a_r) + NW'(acc_c_r)),
    .den   (NW'(acc_b_r) + NW'(1)),
    .done  (d0_done),
    .quo   (q0)
  );

  gdnc_div #(.NW(NW)) u_div_qry (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NW'(acc_b_r) + NW'(acc_c_r)),
    .den   (NW'(acc_a_r) + NW'(1)),
    .done  (d1_done),
    .quo   (q1)
  );

  assign dsum = {1'b0, q0} + {1'b0, q1};
  assign dsat = dsum[SW] ? gdnc_pkg::SCORE_SAT : dsum[SW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdnc_pkg::S_IDLE: begin
        if (in_acc && (in_cmd == gdnc_pkg::CMD_QUERY) && in_last) begin
          state_nxt = gdnc_pkg::S_CLASS;
        end
      end
      gdnc_pkg::S_CLASS: begin
        if (cls_r >= used) begin
          state_nxt = gdnc_pkg::S_DONE;
        end else if (frame_cnt_r[CIW'(cls_r)] != '0) begin
          state_nxt = gdnc_pkg::S_READ;
        end
      end
      gdnc_pkg::S_READ: begin
        if (k_r == KW'(COEFFS - 1)) begin
          state_nxt = gdnc_pkg::S_DRAIN;
        end
      end
      gdnc_pkg::S_DRAIN: begin
        if (div_start) begin
          state_nxt = gdnc_pkg::S_DIV;
        end
      end
      gdnc_pkg::S_DIV: begin
        if (d0_done && d1_done) begin
          state_nxt = gdnc_pkg::S_CMP;
        end
      end
      gdnc_pkg::S_CMP: begin
        if (frm_r + 1'b1 < cnt_r) begin
          state_nxt = gdnc_pkg::S_READ;
        end else begin
          state_nxt = gdnc_pkg::S_CLASS;
        end
      end
      gdnc_pkg::S_DONE: begin
        if (!out_valid_r) begin
          state_nxt = gdnc_pkg::S_IDLE;
        end
      end
      default: state_nxt = gdnc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gdnc_pkg::S_IDLE;
      num_classes_r <= 5'd1;
      out_valid_r   <= 1'b0;
      rd_vld_r      <= 1'b0;
      p_vld_r       <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        frame_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        num_classes_r <= cfg_wdata;
      end
      if (ram_we && (frame_cnt_r[wcls] < new_cnt)) begin
        frame_cnt_r[wcls] <= new_cnt;
      end
      rd_vld_r <= (state_r == gdnc_pkg::S_READ);
      p_vld_r  <= rd_vld_r;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end else if ((state_r == gdnc_pkg::S_DONE) && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == gdnc_pkg::CMD_QUERY) && q_ok) begin
      qm_r[KW'(in_coeff_sel)] <= in_mean_value;
      qv_r[KW'(in_coeff_sel)] <= in_var_value;
    end
    rd_k_r <= k_r;
    pa_r   <= asq;
    pb_r   <= bsq;
    pc_r   <= dsq[31:0];
    if (p_vld_r) begin
      acc_a_r <= acc_a_r + SQW'(pa_r);
      acc_b_r <= acc_b_r + SQW'(pb_r);
      acc_c_r <= acc_c_r + SQW'(pc_r);
    end
    if (state_r == gdnc_pkg::S_READ) begin
      addr_r <= addr_r + 1'b1;
      k_r    <= k_r + 1'b1;
    end
    unique case (state_r)
      gdnc_pkg::S_IDLE: begin
        cls_r   <= '0;
        base_r  <= '0;
        best_r  <= gdnc_pkg::SCORE_BOUND;
        win_r   <= '0;
        found_r <= 1'b0;
      end
      gdnc_pkg::S_CLASS: begin
        cnt_r   <= frame_cnt_r[CIW'(cls_r)];
        frm_r   <= '0;
        k_r     <= '0;
        addr_r  <= base_r;
        acc_a_r <= '0;
        acc_b_r <= '0;
        acc_c_r <= '0;
        if ((cls_r < used) && (frame_cnt_r[CIW'(cls_r)] == '0)) begin
          cls_r  <= cls_r + 1'b1;
          base_r <= base_r + AW'(CSTEP);
        end
      end
      gdnc_pkg::S_CMP: begin
        if (dsat < best_r) begin
          best_r  <= dsat;
          win_r   <= cls_r;
          found_r <= 1'b1;
        end
        frm_r   <= frm_r + 1'b1;
        k_r     <= '0;
        acc_a_r <= '0;
        acc_b_r <= '0;
        acc_c_r <= '0;
        if (!(frm_r + 1'b1 < cnt_r)) begin
          cls_r  <= cls_r + 1'b1;
          base_r <= base_r + AW'(CSTEP);
        end
      end
      gdnc_pkg::S_DONE: begin
        if (!out_valid_r) begin
          out_win_r   <= found_r ? 4'(win_r) : 4'd0;
          out_found_r <= found_r;
          out_dist_r  <= best_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_winner_class = out_win_r;
  assign out_found        = out_found_r;
  assign out_min_distance = out_dist_r;

endmodule

/* design/gdnc_checker.sv */
// Port-level assertions for the nearest-class search, bound to the top level.
module gdnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_cmd,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_winner_class,
  input logic        out_found,
  input logic [39:0] out_min_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_distance))
    else $error("result item dropped while stalled");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_min_distance == gdnc_pkg::SCORE_BOUND && out_winner_class == 4'd0)
    else $error("empty search result malformed");

  a_found_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_min_distance < gdnc_pkg::SCORE_BOUND)
    else $error("found score not below bound");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == gdnc_pkg::CMD_QUERY && in_last |=> in_stall)
    else $error("item taken during search");

endmodule

bind gaussian_divergence_nearest_class gdnc_checker u_gdnc_checker (.*);
